### sv/clpf_pkg.sv
// ----------------------------------------------------------------------------
// clpf_pkg: shared types and constants of the command line pattern filter
// Holds the verdict codes, the allowed name table, the banned text table and
// the request type that the front end hands to the name checker.
// ----------------------------------------------------------------------------
package clpf_pkg;

    localparam int TokenBytes   = 12;
    localparam int WindowBytes  = 10;
    localparam int AllowedCount = 95;
    localparam int BannedCount  = 41;
    localparam int NameBits     = TokenBytes * 8;

    localparam logic [2:0] VerdictSafe      = 3'd0;
    localparam logic [2:0] VerdictEmpty     = 3'd1;
    localparam logic [2:0] VerdictTooLong   = 3'd2;
    localparam logic [2:0] VerdictDangerous = 3'd3;
    localparam logic [2:0] VerdictNotListed = 3'd4;

    localparam logic [12:0] CountMax     = 13'h1FFF;
    localparam logic [11:0] SegmentMax   = 12'hFFF;
    localparam logic [12:0] LengthReset  = 13'd4096;

    // A request from the front end to the back end: a segment close (is_final = 0)
    // or the end of a command with its early verdict; either may carry a name to check.
    typedef struct packed {
        logic                is_final;
        logic                check_name;   // segment has a name to look up
        logic [NameBits-1:0] name;         // byte k in bits [8k+7:8k]
        logic [3:0]          name_len;
        logic [11:0]         segment;
        logic [2:0]          early_verdict;
    } clpf_req_t;

    // Pack a text of up to TokenBytes characters, first character lowest.
    function automatic logic [NameBits-1:0] pack_text(input string s);
        logic [NameBits-1:0] v;
        v = '0;
        for (int k = 0; k < s.len() && k < TokenBytes; k++) begin
            v[k*8 +: 8] = s[k];
        end
        return v;
    endfunction

    function automatic logic [NameBits-1:0] allowed_name(input logic [6:0] idx);
        logic [NameBits-1:0] v;
        v = '0;
        case (idx)
            7'd0:  v = pack_text("acpi");        7'd1:  v = pack_text("awk");
            7'd2:  v = pack_text("cal");         7'd3:  v = pack_text("cargo");
            7'd4:  v = pack_text("cat");         7'd5:  v = pack_text("cut");
            7'd6:  v = pack_text("date");        7'd7:  v = pack_text("df");
            7'd8:  v = pack_text("dig");         7'd9:  v = pack_text("dmidecode");
            7'd10: v = pack_text("du");          7'd11: v = pack_text("echo");
            7'd12: v = pack_text("env");         7'd13: v = pack_text("fastfetch");
            7'd14: v = pack_text("file");        7'd15: v = pack_text("find");
            7'd16: v = pack_text("free");        7'd17: v = pack_text("g++");
            7'd18: v = pack_text("gcc");         7'd19: v = pack_text("git");
            7'd20: v = pack_text("go");          7'd21: v = pack_text("grep");
            7'd22: v = pack_text("head");        7'd23: v = pack_text("hostname");
            7'd24: v = pack_text("hostnamectl"); 7'd25: v = pack_text("htop");
            7'd26: v = pack_text("ifconfig");    7'd27: v = pack_text("iostat");
            7'd28: v = pack_text("ip");          7'd29: v = pack_text("iw");
            7'd30: v = pack_text("iwconfig");    7'd31: v = pack_text("java");
            7'd32: v = pack_text("javac");       7'd33: v = pack_text("journalctl");
            7'd34: v = pack_text("loginctl");    7'd35: v = pack_text("ls");
            7'd36: v = pack_text("lsblk");       7'd37: v = pack_text("lscpu");
            7'd38: v = pack_text("lshw");        7'd39: v = pack_text("lsmem");
            7'd40: v = pack_text("lsof");        7'd41: v = pack_text("lspci");
            7'd42: v = pack_text("lsusb");       7'd43: v = pack_text("md5sum");
            7'd44: v = pack_text("mkdir");       7'd45: v = pack_text("neofetch");
            7'd46: v = pack_text("netstat");     7'd47: v = pack_text("nmcli");
            7'd48: v = pack_text("node");        7'd49: v = pack_text("npm");
            7'd50: v = pack_text("nslookup");    7'd51: v = pack_text("pgrep");
            7'd52: v = pack_text("ping");        7'd53: v = pack_text("pip");
            7'd54: v = pack_text("pip3");        7'd55: v = pack_text("pmap");
            7'd56: v = pack_text("printenv");    7'd57: v = pack_text("ps");
            7'd58: v = pack_text("pwd");         7'd59: v = pack_text("python");
            7'd60: v = pack_text("python3");     7'd61: v = pack_text("readlink");
            7'd62: v = pack_text("realpath");    7'd63: v = pack_text("rustc");
            7'd64: v = pack_text("sar");         7'd65: v = pack_text("screenfetch");
            7'd66: v = pack_text("sed");         7'd67: v = pack_text("sensors");
            7'd68: v = pack_text("sha256sum");   7'd69: v = pack_text("sleep");
            7'd70: v = pack_text("sort");        7'd71: v = pack_text("ss");
            7'd72: v = pack_text("stat");        7'd73: v = pack_text("strace");
            7'd74: v = pack_text("strings");     7'd75: v = pack_text("systemctl");
            7'd76: v = pack_text("tail");        7'd77: v = pack_text("tee");
            7'd78: v = pack_text("timedatectl"); 7'd79: v = pack_text("top");
            7'd80: v = pack_text("touch");       7'd81: v = pack_text("tr");
            7'd82: v = pack_text("traceroute");  7'd83: v = pack_text("type");
            7'd84: v = pack_text("uname");       7'd85: v = pack_text("uniq");
            7'd86: v = pack_text("upower");      7'd87: v = pack_text("uptime");
            7'd88: v = pack_text("vmstat");      7'd89: v = pack_text("wc");
            7'd90: v = pack_text("whereis");     7'd91: v = pack_text("which");
            7'd92: v = pack_text("who");         7'd93: v = pack_text("whoami");
            7'd94: v = pack_text("xargs");
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic int allowed_len(input logic [6:0] idx);
        logic [NameBits-1:0] v;
        int n;
        v = allowed_name(idx);
        n = 0;
        for (int k = 0; k < TokenBytes; k++) begin
            if (v[k*8 +: 8] != 8'd0) n = k + 1;
        end
        return n;
    endfunction

    function automatic string banned_text(input int idx);
        string s;
        s = "";
        case (idx)
            0: s = "sudo ";    1: s = "sudo\t";   2: s = " su ";     3: s = "\tsu ";
            4: s = " rm ";     5: s = "\trm ";    6: s = " rm\t";    7: s = " dd ";
            8: s = "mkfs";     9: s = "fdisk";    10: s = "chmod ";  11: s = "chown ";
            12: s = " kill ";  13: s = "killall"; 14: s = "pkill";   15: s = "reboot";
            16: s = "shutdown"; 17: s = "poweroff"; 18: s = "init "; 19: s = "> /";
            20: s = ">> /";    21: s = ">/";      22: s = ">>/";     23: s = "| sh";
            24: s = "| bash";  25: s = "|sh";     26: s = "|bash";   27: s = "eval ";
            28: s = "exec ";   29: s = ":(){";    30: s = "format";  31: s = "nc -e";
            32: s = "nc -l";   33: s = "/dev/sd"; 34: s = "/dev/nvme"; 35: s = "passwd";
            36: s = "useradd"; 37: s = "userdel"; 38: s = "mv /";    39: s = "cp /";
            40: s = "mkdir -p /";
            default: s = "";
        endcase
        return s;
    endfunction

endpackage

### sv/command_line_pattern_filter.sv
// ----------------------------------------------------------------------------
// command_line_pattern_filter: top level of the command line pattern filter
// Scans a command byte by byte and gives one verdict per command.
//
//   Channel | Direction | Contents
//   s_axis  | in        | tdata = char_byte[7:0], tuser = ends_command
//   m_axis  | out       | tdata = verdict[2:0], failing_segment[14:3], 0 pad
//   cfg     | in        | max_length[12:0]
//
// Each pipe that closes a segment with bytes, and every terminator, sends a
// request into a four-entry queue. The checker picks up a request and, when
// it has a name to check, runs a binary search over the allowed-name table;
// a verdict is offered once the terminator's request has passed the queue
// and the checker. A pipe or terminator stalls only when the queue is full.
// The result sits in a register until taken.
// Reset (aresetn low, synchronous) clears all command state and sets
// max_length to 4096.
// ----------------------------------------------------------------------------
module command_line_pattern_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,     // max_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // char_byte
    input  logic        s_axis_tuser,    // ends_command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // verdict[2:0], failing_segment[14:3]
);

    logic [12:0] max_length_reg;
    logic        f_valid, f_ready, b_valid, b_ready;
    clpf_pkg::clpf_req_t f_req, b_req;
    logic [2:0]  verdict;
    logic [11:0] segment;

    always_ff @(posedge aclk) begin
        if (!aresetn)       max_length_reg <= clpf_pkg::LengthReset;
        else if (cfg_wr_en) max_length_reg <= cfg_wr_data;
    end

    clpf_front u_front (
        .aclk, .aresetn,
        .max_length (max_length_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tuser),
        .req_valid  (f_valid),
        .req_ready  (f_ready),
        .req        (f_req)
    );

    clpf_queue u_queue (
        .aclk, .aresetn,
        .wr_valid (f_valid), .wr_ready (f_ready), .wr_data (f_req),
        .rd_valid (b_valid), .rd_ready (b_ready), .rd_data (b_req)
    );

    clpf_back u_back (
        .aclk, .aresetn,
        .req_valid   (b_valid),
        .req_ready   (b_ready),
        .req         (b_req),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_verdict (verdict),
        .out_segment (segment)
    );

    assign m_axis_tdata = {1'b0, segment, verdict};

endmodule

### sv/clpf_front.sv
// ----------------------------------------------------------------------------
// clpf_front: byte scanner of the command line pattern filter
// Lowercases bytes into a window, flags banned texts, tracks segments and
// their names, and posts name checks and the command end into the queue.
// ----------------------------------------------------------------------------
module clpf_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [12:0]          max_length,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output logic                 req_valid,
    input  logic                 req_ready,
    output clpf_pkg::clpf_req_t  req
);

    localparam int WB = clpf_pkg::WindowBytes;
    localparam int TB = clpf_pkg::TokenBytes;

    logic [7:0]  window_reg [WB];
    logic        pattern_reg;
    logic [12:0] count_reg;
    logic [7:0]  token_reg [TB];
    logic [3:0]  tlen_reg;
    logic        tover_reg;
    logic [1:0]  phase_reg;
    logic        has_bytes_reg;
    logic [11:0] seg_reg;

    logic        take, is_pipe, is_blank, closes, hit;
    logic [7:0]  lc;
    logic [7:0]  win_new [WB];

    assign is_pipe  = (in_byte == 8'h7C);
    assign is_blank = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
    assign lc       = (in_byte >= 8'h41 && in_byte <= 8'h5A) ? in_byte + 8'd32 : in_byte;

    // A pipe or a terminator closes a segment; a pipe posts only for a segment with bytes, a terminator always posts.
    assign closes   = in_last || is_pipe;
    assign in_ready = !(closes && (has_bytes_reg || in_last)) || req_ready;
    assign take     = in_valid && in_ready;
    assign req_valid = in_valid && closes && (has_bytes_reg || in_last);

    always_comb begin
        for (int k = 0; k < WB - 1; k++) win_new[k] = window_reg[k+1];
        win_new[WB-1] = lc;
    end

    always_comb begin
        string t;
        int    n;
        logic  m;
        hit = 1'b0;
        for (int p = 0; p < clpf_pkg::BannedCount; p++) begin
            t = clpf_pkg::banned_text(p);
            n = t.len();
            m = (n > 0) && (n <= WB);
            for (int k = 0; k < WB; k++) begin
                if (m && k < n && win_new[WB-n+k] != t[k]) m = 1'b0;
            end
            if (m) hit = 1'b1;
        end
    end

    always_comb begin
        logic [12:0] cnt;
        req = '0;
        for (int k = 0; k < TB; k++) req.name[k*8 +: 8] = token_reg[k];
        req.name_len   = tlen_reg;
        req.segment    = seg_reg;
        req.is_final   = in_last;
        req.check_name = has_bytes_reg && (tlen_reg != 4'd0 || tover_reg) && !tover_reg;
        // An overflowed name always fails: flag it as a length no name has.
        if (has_bytes_reg && tover_reg) begin
            req.check_name = 1'b1;
            req.name_len   = 4'd15;
        end
        cnt = count_reg;
        if (count_reg == 13'd0)           req.early_verdict = clpf_pkg::VerdictEmpty;
        else if (cnt > max_length)        req.early_verdict = clpf_pkg::VerdictTooLong;
        else if (pattern_reg)             req.early_verdict = clpf_pkg::VerdictDangerous;
        else                              req.early_verdict = clpf_pkg::VerdictSafe;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && in_last)) begin
            for (int k = 0; k < WB; k++) window_reg[k] <= 8'd0;
            pattern_reg   <= 1'b0;
            count_reg     <= '0;
            tlen_reg      <= '0;
            tover_reg     <= 1'b0;
            phase_reg     <= 2'd0;
            has_bytes_reg <= 1'b0;
            seg_reg       <= '0;
        end else if (take) begin
            window_reg <= win_new;
            if (hit) pattern_reg <= 1'b1;
            if (count_reg != clpf_pkg::CountMax) count_reg <= count_reg + 13'd1;
            if (is_pipe) begin
                if (has_bytes_reg && seg_reg != clpf_pkg::SegmentMax)
                    seg_reg <= seg_reg + 12'd1;
                tlen_reg      <= '0;
                tover_reg     <= 1'b0;
                phase_reg     <= 2'd0;
                has_bytes_reg <= 1'b0;
            end else begin
                has_bytes_reg <= 1'b1;
                if ((phase_reg == 2'd0 && !is_blank) || (phase_reg == 2'd1 && !is_blank)) begin
                    phase_reg <= 2'd1;
                    if (in_byte == 8'h2F) begin
                        tlen_reg  <= '0;
                        tover_reg <= 1'b0;
                    end else if (tlen_reg < 4'(TB)) begin
                        token_reg[tlen_reg] <= in_byte;
                        tlen_reg <= tlen_reg + 4'd1;
                    end else begin
                        tover_reg <= 1'b1;
                    end
                end else if (phase_reg == 2'd1) begin
                    phase_reg <= 2'd2;
                end
            end
        end
    end

endmodule

### sv/clpf_queue.sv
// ----------------------------------------------------------------------------
// clpf_queue: short request queue between the scanner and the name checker
// A four-entry circular buffer in registers; a fill count gives full and empty.
// ----------------------------------------------------------------------------
module clpf_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  clpf_pkg::clpf_req_t  wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output clpf_pkg::clpf_req_t  rd_data
);

    clpf_pkg::clpf_req_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] fill_reg;

    assign wr_ready = (fill_reg != 3'd4);
    assign rd_valid = (fill_reg != 3'd0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_valid && wr_ready) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= wp_reg + 2'd1;
            if (rd_valid && rd_ready) rp_reg <= rp_reg + 2'd1;
            fill_reg <= fill_reg + 3'(wr_valid && wr_ready) - 3'(rd_valid && rd_ready);
        end
    end

endmodule

### sv/clpf_back.sv
// ----------------------------------------------------------------------------
// clpf_back: name checker and verdict stage
// Binary search over the sorted allowed names, eight probes at most per name,
// then records the first failing segment and issues the verdict on a command
// end.
// ----------------------------------------------------------------------------
module clpf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  clpf_pkg::clpf_req_t  req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           out_verdict,
    output logic [11:0]          out_segment
);

    localparam int NB = clpf_pkg::NameBits;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_OUT    = 3'b100
    } state_t;

    state_t      state_reg;
    logic [7:0]  lo_reg, hi_reg;     // half-open range [lo, hi)
    logic        fail_reg;
    logic [11:0] fidx_reg;
    logic [2:0]  verdict_reg;
    logic [11:0] segout_reg;

    logic [6:0]    mid;
    logic [NB-1:0] probe;
    logic [3:0]    plen;
    logic          eq, less;   // key < probe

    assign mid   = 7'((lo_reg + hi_reg) >> 1);
    assign probe = clpf_pkg::allowed_name(mid);
    assign plen  = 4'(clpf_pkg::allowed_len(mid));

    // Byte reversal so a plain unsigned compare gives text order; bytes past
    // the key length are zero, which sorts before every printable byte.
    always_comb begin
        logic [NB-1:0] k, p;
        for (int i = 0; i < clpf_pkg::TokenBytes; i++) begin
            k[NB-8-i*8 +: 8] = (4'(i) < req.name_len) ? req.name[i*8 +: 8] : 8'd0;
            p[NB-8-i*8 +: 8] = probe[i*8 +: 8];
        end
        eq   = (k == p) && (plen == req.name_len);
        less = (k < p);
    end

    assign req_ready   = (state_reg == ST_IDLE && req_valid && !req.check_name) ||
                         (state_reg == ST_SEARCH && (eq || lo_reg + 8'd1 >= hi_reg));
    assign out_valid   = (state_reg == ST_OUT);
    assign out_verdict = verdict_reg;
    assign out_segment = segout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fail_reg  <= 1'b0;
            fidx_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (req_valid) begin
                        if (req.check_name) begin
                            lo_reg    <= '0;
                            hi_reg    <= 8'(clpf_pkg::AllowedCount);
                            state_reg <= ST_SEARCH;
                        end else if (req.is_final) begin
                            segout_reg <= '0;
                            verdict_reg <= req.early_verdict;
                            if (req.early_verdict == clpf_pkg::VerdictSafe && fail_reg) begin
                                verdict_reg <= clpf_pkg::VerdictNotListed;
                                segout_reg  <= fidx_reg;
                            end
                            fail_reg  <= 1'b0;
                            fidx_reg  <= '0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (eq || lo_reg + 8'd1 >= hi_reg) begin
                        if (!eq && !fail_reg) begin
                            fail_reg <= 1'b1;
                            fidx_reg <= req.segment;
                        end
                        if (req.is_final) begin
                            segout_reg  <= '0;
                            verdict_reg <= req.early_verdict;
                            if (req.early_verdict == clpf_pkg::VerdictSafe &&
                                (fail_reg || !eq)) begin
                                verdict_reg <= clpf_pkg::VerdictNotListed;
                                segout_reg  <= fail_reg ? fidx_reg : req.segment;
                            end
                            fail_reg  <= 1'b0;
                            fidx_reg  <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end else if (less) begin
                        hi_reg <= {1'b0, mid};
                    end else begin
                        lo_reg <= {1'b0, mid};
                    end
                end
                ST_OUT: begin
                    if (out_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
